/* rtl/keypad_alarm_controller_top_macros.svh */
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef KEYPAD_ALARM_CONTROLLER_TOP_MACROS_SVH
`define KEYPAD_ALARM_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define KAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/kac_pkg.sv */
// ----------------------------------------------------------------------------
// kac_pkg
// Shared codes, characters and message header type of the keypad alarm.
// ----------------------------------------------------------------------------
package kac_pkg;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_IDLE     = 2'd0;
  localparam mode_t MODE_ENTRY    = 2'd1;
  localparam mode_t MODE_DISARMED = 2'd2;

  typedef logic [1:0] op_t;
  localparam op_t OP_MOTION = 2'd0;
  localparam op_t OP_KEY    = 2'd1;
  localparam op_t OP_TICK   = 2'd2;
  localparam op_t OP_REARM  = 2'd3;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [3:0] DIGIT_HI = 4'h3;

  localparam logic [15:0] SECRET_RST  = 16'h0423;
  localparam logic [15:0] TIMEOUT_RST = 16'd10;
  localparam logic [15:0] SEC_MAX     = 16'hFFFF;

  localparam logic REG_SECRET  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [7:0] head;
    logic       has_digits;
    logic       alarm;
    mode_t      mode;
  } msg_hdr_t;

endpackage

/* rtl/kac_front.sv */
// ----------------------------------------------------------------------------
// kac_front
// Event decoder and controller state; posts one message per event that speaks.
// ----------------------------------------------------------------------------
module kac_front #(
  parameter int CODE_DIGITS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_operation,
  input  logic [7:0]               in_key_char,
  input  logic [15:0]              secret_code,
  input  logic [15:0]              timeout_seconds,
  input  logic                     q_full,
  output logic                     q_push,
  output kac_pkg::msg_hdr_t        q_hdr,
  output logic [4*CODE_DIGITS-1:0] q_digits
);

  localparam int EW = 4 * CODE_DIGITS;
  localparam int CW = $clog2(CODE_DIGITS + 1);

  kac_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]     buf_r   [CODE_DIGITS];
  logic [3:0]     buf_nxt [CODE_DIGITS];
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [15:0]    sec_r, sec_nxt;
  logic           run_r, run_nxt;
  logic           alarm_r, alarm_nxt;

  logic [EW-1:0]  buf_flat;
  logic [EW-1:0]  code_ext;
  logic           match;
  logic           is_digit;
  logic           acc;
  logic [15:0]    sec_inc;
  logic           emit;
  logic [7:0]     head;
  logic           with_digits;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign is_digit = (in_key_char >= kac_pkg::CH_0) && (in_key_char <= kac_pkg::CH_9);
  assign sec_inc  = (sec_r == kac_pkg::SEC_MAX) ? sec_r : sec_r + 16'd1;

  // first digit sits in the top nibble; nibbles above bit 15 read as zero
  assign code_ext = EW'(secret_code);

  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      buf_flat[4*(CODE_DIGITS-1-i) +: 4] = buf_r[i];
    end
  end

  assign match = (buf_flat == code_ext);

  always_comb begin
    mode_nxt    = mode_r;
    buf_nxt     = buf_r;
    cnt_nxt     = cnt_r;
    sec_nxt     = sec_r;
    run_nxt     = run_r;
    alarm_nxt   = alarm_r;
    emit        = 1'b0;
    head        = kac_pkg::CH_M;
    with_digits = 1'b0;
    unique case (in_operation)
      kac_pkg::OP_MOTION: begin
        if (mode_r == kac_pkg::MODE_IDLE) begin
          mode_nxt = kac_pkg::MODE_ENTRY;
          run_nxt  = 1'b1;
          sec_nxt  = '0;
          emit     = 1'b1;
          head     = kac_pkg::CH_M;
        end
      end
      kac_pkg::OP_KEY: begin
        if (mode_r == kac_pkg::MODE_ENTRY) begin
          if (is_digit) begin
            if (cnt_r == CW'(CODE_DIGITS)) begin
              // full: drop the oldest digit
              for (int i = 0; i < CODE_DIGITS - 1; i++) begin
                buf_nxt[i] = buf_r[i+1];
              end
              buf_nxt[CODE_DIGITS-1] = in_key_char[3:0];
            end else begin
              for (int i = 0; i < CODE_DIGITS; i++) begin
                if (cnt_r == CW'(i)) buf_nxt[i] = in_key_char[3:0];
              end
              cnt_nxt = cnt_r + CW'(1);
            end
          end else if (in_key_char == kac_pkg::CH_D) begin
            if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
          end else if (in_key_char == kac_pkg::CH_A && cnt_r == CW'(CODE_DIGITS)) begin
            emit        = 1'b1;
            with_digits = 1'b1;
            if (match) begin
              alarm_nxt = 1'b0;
              run_nxt   = 1'b0;
              sec_nxt   = '0;
              mode_nxt  = kac_pkg::MODE_DISARMED;
              head      = kac_pkg::CH_C;
            end else begin
              alarm_nxt = 1'b1;
              head      = kac_pkg::CH_W;
            end
            for (int i = 0; i < CODE_DIGITS; i++) buf_nxt[i] = '0;
            cnt_nxt = '0;
          end
        end
      end
      kac_pkg::OP_TICK: begin
        if (run_r) begin
          if (sec_inc >= timeout_seconds) begin
            alarm_nxt = 1'b1;
            run_nxt   = 1'b0;
            sec_nxt   = '0;
            emit      = 1'b1;
            head      = kac_pkg::CH_T;
          end else begin
            sec_nxt = sec_inc;
          end
        end
      end
      kac_pkg::OP_REARM: begin
        if (mode_r == kac_pkg::MODE_DISARMED) begin
          mode_nxt = kac_pkg::MODE_IDLE;
          sec_nxt  = '0;
          emit     = 1'b1;
          head     = kac_pkg::CH_R;
        end
      end
      default: ;
    endcase
  end

  assign q_push            = acc && emit;
  assign q_hdr.head        = head;
  assign q_hdr.has_digits  = with_digits;
  assign q_hdr.alarm       = alarm_nxt;
  assign q_hdr.mode        = mode_nxt;
  assign q_digits          = buf_flat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= kac_pkg::MODE_IDLE;
      cnt_r   <= '0;
      sec_r   <= '0;
      run_r   <= 1'b0;
      alarm_r <= 1'b0;
      for (int i = 0; i < CODE_DIGITS; i++) buf_r[i] <= '0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      sec_r   <= sec_nxt;
      run_r   <= run_nxt;
      alarm_r <= alarm_nxt;
      buf_r   <= buf_nxt;
    end
  end

endmodule

/* rtl/kac_fifo.sv */
// ----------------------------------------------------------------------------
// kac_fifo
// Two-entry message queue between the event front and the byte serializer.
// ----------------------------------------------------------------------------
module kac_fifo #(
  parameter int WIDTH = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/kac_back.sv */
// ----------------------------------------------------------------------------
// kac_back
// Message serializer: header, then any digits, one word a cycle while out_ready.
// ----------------------------------------------------------------------------
module kac_back #(
  parameter int CODE_DIGITS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  kac_pkg::msg_hdr_t        q_hdr,
  input  logic [4*CODE_DIGITS-1:0] q_digits,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_message_byte,
  output logic                     out_last_byte,
  output logic                     out_alarm_on,
  output logic [1:0]               out_mode
);

  localparam int EW = 4 * CODE_DIGITS;
  localparam int IW = $clog2(CODE_DIGITS + 1);

  logic              busy_r;
  kac_pkg::msg_hdr_t hdr_r;
  logic [EW-1:0]     digs_r;
  logic [IW-1:0]     idx_r;
  logic              last;
  logic              done;

  assign last  = !hdr_r.has_digits || (idx_r == IW'(CODE_DIGITS));
  assign done  = busy_r && out_ready && last;
  assign q_pop = q_valid && (!busy_r || done);

  assign out_valid        = busy_r;
  assign out_last_byte    = last;
  assign out_alarm_on     = hdr_r.alarm;
  assign out_mode         = hdr_r.mode;
  // a digit d prints as ASCII '0'+d
  assign out_message_byte = (idx_r == '0) ? hdr_r.head
                                          : {kac_pkg::DIGIT_HI, digs_r[EW-1 -: 4]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r && out_ready) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hdr_r  <= q_hdr;
      digs_r <= q_digits;
    end else if (busy_r && out_ready && idx_r != '0) begin
      digs_r <= digs_r << 4;
    end
  end

endmodule

/* rtl/keypad_alarm_controller_top.sv */
// ----------------------------------------------------------------------------
// keypad_alarm_controller_top
// Keypad alarm controller: event front, message queue, byte serializer.
// ----------------------------------------------------------------------------
// Input channel: one word per event (operation, key_char). Motion, key press,
// tick and rearm update the controller state in the cycle they are accepted.
// Output channel: one word per message byte, with last_byte on the final byte
// and alarm_on/mode giving the state after the event that caused it.
// Events that cause no message leave no output.
// A message passes the queue entry, then the serializer's header register.
// Throughput: the front takes one event per cycle while the queue has room;
// the serializer sends one byte per cycle while out_ready is high. M, T and R
// messages are one byte, W/C messages CODE_DIGITS+1 bytes. The two-entry
// queue between them sets how far the front can run ahead.
// When the receiver stalls, the current word holds and the queue fills;
// in_ready drops only when the queue is full.
// Reset (synchronous rst_n low): idle mode, empty entry, countdown stopped,
// alarm off, queue empty, registers back to code 0423 and 10 s timeout.
// Config writes (APB, pready always high): 0x0 secret_code, 0x4 timeout.
// ----------------------------------------------------------------------------
module keypad_alarm_controller_top #(
  parameter int CODE_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_key_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_message_byte,
  output logic        out_last_byte,
  output logic        out_alarm_on,
  output logic [1:0]  out_mode,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int EW = 4 * CODE_DIGITS;
  localparam int QW = $bits(kac_pkg::msg_hdr_t) + EW;

  logic [15:0]       secret_r;
  logic [15:0]       timeout_r;
  logic              wr_en;

  logic              q_full;
  logic              q_push;
  kac_pkg::msg_hdr_t push_hdr;
  logic [EW-1:0]     push_digits;
  logic              q_pop;
  logic              q_valid;
  logic [QW-1:0]     q_pop_data;
  kac_pkg::msg_hdr_t pop_hdr;
  logic [EW-1:0]     pop_digits;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secret_r  <= kac_pkg::SECRET_RST;
      timeout_r <= kac_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      if (paddr[2] == kac_pkg::REG_SECRET) secret_r  <= pwdata[15:0];
      else                                 timeout_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == kac_pkg::REG_TIMEOUT) ? {16'd0, timeout_r}
                                                     : {16'd0, secret_r};

  kac_front #(.CODE_DIGITS(CODE_DIGITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key_char     (in_key_char),
    .secret_code     (secret_r),
    .timeout_seconds (timeout_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_hdr           (push_hdr),
    .q_digits        (push_digits)
  );

  kac_fifo #(.WIDTH(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_hdr, push_digits}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  assign pop_hdr    = q_pop_data[QW-1 -: $bits(kac_pkg::msg_hdr_t)];
  assign pop_digits = q_pop_data[EW-1:0];

  kac_back #(.CODE_DIGITS(CODE_DIGITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_hdr            (pop_hdr),
    .q_digits         (pop_digits),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_message_byte (out_message_byte),
    .out_last_byte    (out_last_byte),
    .out_alarm_on     (out_alarm_on),
    .out_mode         (out_mode)
  );

endmodule

/* rtl/kac_checker.sv */
// ----------------------------------------------------------------------------
// kac_checker
// Port-level checks of the keypad alarm controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "keypad_alarm_controller_top_macros.svh"

module kac_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_message_byte,
  input logic       out_last_byte,
  input logic       out_alarm_on,
  input logic [1:0] out_mode
);

  // a stalled word must hold
  `KAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_message_byte) && $stable(out_last_byte), "output word changed while stalled")

  // motion opens code entry with a single-byte message
  `KAC_ASSERT_NOW(a_motion_msg, out_valid && out_message_byte == kac_pkg::CH_M, out_last_byte && out_mode == kac_pkg::MODE_ENTRY, "M word with wrong mode or length")

  // correct code: alarm off, disarmed, digits follow
  `KAC_ASSERT_NOW(a_correct_msg, out_valid && out_message_byte == kac_pkg::CH_C, !out_alarm_on && !out_last_byte && out_mode == kac_pkg::MODE_DISARMED, "C word with wrong state")

  // wrong code or timeout: alarm must be on
  `KAC_ASSERT_NOW(a_alarm_msg, out_valid && (out_message_byte == kac_pkg::CH_W || out_message_byte == kac_pkg::CH_T), out_alarm_on, "W or T word without alarm")

endmodule

bind keypad_alarm_controller_top kac_checker u_kac_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_message_byte (out_message_byte),
  .out_last_byte    (out_last_byte),
  .out_alarm_on     (out_alarm_on),
  .out_mode         (out_mode)
);

/* bench/keypad_alarm_controller_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_alarm_controller_top_test
// The test first drives a short scripted sequence of keypad, motion, tick and
// rearm events, then random phases under several code and timeout settings.
// Script rows or a bench model give every expected word. Each returned word is
// checked field by field, in order, while both handshakes stall at random.
// ----------------------------------------------------------------------------
module keypad_alarm_controller_top_test;

  localparam int NDIG = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 30;

  typedef struct packed {
    logic [7:0]     ch;
    logic           last;
    logic           alarm;
    kac_pkg::mode_t mode;
  } msg_byte_t;

  typedef struct {
    kac_pkg::op_t   op;
    logic [7:0]     key;
    bit             typed;
    string          msg;
    logic           alarm;
    kac_pkg::mode_t mode;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  kac_pkg::op_t in_operation;
  logic [7:0]   in_key_char;
  logic         out_valid;
  logic         out_ready;
  logic [7:0]   out_message_byte;
  logic         out_last_byte;
  logic         out_alarm_on;
  logic [1:0]   out_mode;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // bench copy of the controller state and registers
  kac_pkg::mode_t cur_mode;
  logic [3:0]     digits [NDIG];
  int             ndig;
  int             secs;
  bit             running;
  logic           alarm_lvl;
  logic [15:0]    code_reg;
  logic [15:0]    limit_reg;

  msg_byte_t   staged[$];
  msg_byte_t   due_msg_bytes[$];
  stim_row_t   script[$];
  int          errors;
  int          quiet = 0;
  bit          calm;

  keypad_alarm_controller_top #(.CODE_DIGITS(NDIG)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_key_char      (in_key_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_message_byte (out_message_byte),
    .out_last_byte    (out_last_byte),
    .out_alarm_on     (out_alarm_on),
    .out_mode         (out_mode),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic log_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic void put_byte(logic [7:0] ch, logic last);
    staged.push_back(msg_byte_t'{ch, last, alarm_lvl, cur_mode});
  endfunction

  // Advances the bench state by one event; the words it causes go to staged.
  // Returns 1 when the event was not simply dropped.
  function automatic bit alarm_event(kac_pkg::op_t op, logic [7:0] key);
    bit hit;
    bit match;
    int i;
    hit = 1'b0;
    staged.delete();
    case (op)
      kac_pkg::OP_MOTION: begin
        if (cur_mode == kac_pkg::MODE_IDLE) begin
          cur_mode = kac_pkg::MODE_ENTRY;
          running = 1'b1;
          secs = 0;
          put_byte(kac_pkg::CH_M, 1'b1);
          hit = 1'b1;
        end
      end
      kac_pkg::OP_KEY: begin
        if (cur_mode == kac_pkg::MODE_ENTRY) begin
          if (key >= kac_pkg::CH_0 && key <= kac_pkg::CH_9) begin
            if (ndig >= NDIG) begin
              for (i = 0; i < NDIG - 1; i++) digits[i] = digits[i + 1];
              ndig = NDIG - 1;
            end
            digits[ndig] = 4'(key - kac_pkg::CH_0);
            ndig++;
            hit = 1'b1;
          end else if (key == kac_pkg::CH_D) begin
            if (ndig > 0) begin
              ndig--;
              hit = 1'b1;
            end
          end else if (key == kac_pkg::CH_A && ndig == NDIG) begin
            match = 1'b1;
            for (i = 0; i < NDIG; i++) begin
              if (code_reg[4*(NDIG-1-i) +: 4] != digits[i]) match = 1'b0;
            end
            if (match) begin
              alarm_lvl = 1'b0;
              running = 1'b0;
              secs = 0;
              cur_mode = kac_pkg::MODE_DISARMED;
              put_byte(kac_pkg::CH_C, 1'b0);
            end else begin
              alarm_lvl = 1'b1;
              put_byte(kac_pkg::CH_W, 1'b0);
            end
            for (i = 0; i < NDIG; i++)
              put_byte(kac_pkg::CH_0 + 8'(digits[i]), i == NDIG - 1);
            for (i = 0; i < NDIG; i++) digits[i] = 4'd0;
            ndig = 0;
            hit = 1'b1;
          end
        end
      end
      kac_pkg::OP_TICK: begin
        if (running) begin
          if (secs < 65535) secs++;
          if (secs >= int'(limit_reg)) begin
            alarm_lvl = 1'b1;
            running = 1'b0;
            secs = 0;
            put_byte(kac_pkg::CH_T, 1'b1);
          end
          hit = 1'b1;
        end
      end
      default: begin
        if (cur_mode == kac_pkg::MODE_DISARMED) begin
          cur_mode = kac_pkg::MODE_IDLE;
          secs = 0;
          put_byte(kac_pkg::CH_R, 1'b1);
          hit = 1'b1;
        end
      end
    endcase
    return hit;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Mostly well-formed entry sessions, steered by the bench state, plus noise.
  function automatic void random_event(output kac_pkg::op_t op, output logic [7:0] key);
    int r;
    int s;
    logic [3:0] d;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    op = kac_pkg::OP_KEY;
    key = 8'($urandom_range(0, 255));
    if (r < 8) begin
      op = kac_pkg::op_t'($urandom_range(0, 3));
    end else begin
      case (cur_mode)
        kac_pkg::MODE_IDLE:
          op = (s < 85) ? kac_pkg::OP_MOTION : kac_pkg::op_t'($urandom_range(0, 3));
        kac_pkg::MODE_ENTRY: begin
          if (s < 12) begin
            op = kac_pkg::OP_TICK;
          end else if (s < 18) begin
            key = kac_pkg::CH_D;
          end else if (s < 21 || (ndig == NDIG && s < 75)) begin
            key = kac_pkg::CH_A;
          end else begin
            if (ndig < NDIG && $urandom_range(0, 3) != 0) d = code_reg[4*(NDIG-1-ndig) +: 4];
            else d = 4'($urandom_range(0, 9));
            key = kac_pkg::CH_0 + 8'(d);
          end
        end
        default:
          op = (s < 65) ? kac_pkg::OP_REARM : kac_pkg::op_t'($urandom_range(0, 3));
      endcase
    end
  endfunction

  task automatic send_event(input kac_pkg::op_t op, input logic [7:0] key, input bit typed,
                            input string msg, input logic alarm, input kac_pkg::mode_t md,
                            output bit hit);
    int gap;
    int k;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_operation = op;
    in_key_char = key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hit = alarm_event(op, key);
    if (typed) begin
      for (k = 0; k < msg.len(); k++)
        due_msg_bytes.push_back(msg_byte_t'{msg[k], k == msg.len() - 1, alarm, md});
    end else begin
      foreach (staged[k]) due_msg_bytes.push_back(staged[k]);
    end
  endtask

  // drain, then give events with no message time to leave the pipeline
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_msg_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_reg(logic idx, logic [15:0] val);
    logic [15:0] got;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {16'h0000, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == kac_pkg::REG_SECRET) code_reg = val;
    else limit_reg = val;
    // read back
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata[15:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== val) log_mismatch($sformatf("reg %0d read %h, wrote %h", idx, got, val));
  endtask

  function automatic void add_row(kac_pkg::op_t op, logic [7:0] key, bit typed, string msg,
                                  logic alarm, kac_pkg::mode_t md);
    stim_row_t r;
    r.op = op;
    r.key = key;
    r.typed = typed;
    r.msg = msg;
    r.alarm = alarm;
    r.mode = md;
    script.push_back(r);
  endfunction

  // receiver pacing
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:64]:  hold = 0;
          [65:94]: hold = $urandom_range(1, 3);
          default: hold = $urandom_range(15, 40);
        endcase
        if (calm) hold = 0;
        out_ready = (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  always @(posedge clk) begin : check_words
    msg_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_msg_bytes.size() == 0) begin
        log_mismatch($sformatf("unexpected word %h", out_message_byte));
      end else begin
        want = due_msg_bytes.pop_front();
        if (out_message_byte !== want.ch)
          log_mismatch($sformatf("message_byte %h, want %h", out_message_byte, want.ch));
        if (out_last_byte !== want.last)
          log_mismatch($sformatf("last_byte %b, want %b on %h", out_last_byte, want.last,
                                 want.ch));
        if (out_alarm_on !== want.alarm)
          log_mismatch($sformatf("alarm_on %b, want %b on %h", out_alarm_on, want.alarm,
                                 want.ch));
        if (out_mode !== want.mode)
          log_mismatch($sformatf("mode %0d, want %0d on %h", out_mode, want.mode, want.ch));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("keypad_alarm_controller_top test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int n;
    int phase;
    int done_items;
    kac_pkg::op_t op;
    logic [7:0] key;
    bit hit;
    logic [15:0] code;
    logic [15:0] limit;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = kac_pkg::OP_MOTION;
    in_key_char = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'h0;
    errors = 0;
    calm = 1'b0;
    cur_mode = kac_pkg::MODE_IDLE;
    for (n = 0; n < NDIG; n++) digits[n] = 4'd0;
    ndig = 0;
    secs = 0;
    running = 1'b0;
    alarm_lvl = 1'b0;
    code_reg = kac_pkg::SECRET_RST;
    limit_reg = kac_pkg::TIMEOUT_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // events in the wrong mode, short accept, delete on empty, unknown keys
    add_row(kac_pkg::OP_TICK, 8'h00, 1, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_REARM, 8'hFF, 1, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd5, 1, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_MOTION, 8'hA5, 1, "M", 1'b0, kac_pkg::MODE_ENTRY);
    add_row(kac_pkg::OP_MOTION, 8'h00, 1, "", 1'b0, kac_pkg::MODE_ENTRY);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_A, 1, "", 1'b0, kac_pkg::MODE_ENTRY);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_D, 1, "", 1'b0, kac_pkg::MODE_ENTRY);
    add_row(kac_pkg::OP_KEY, 8'h00, 1, "", 1'b0, kac_pkg::MODE_ENTRY);
    add_row(kac_pkg::OP_KEY, 8'hFF, 1, "", 1'b0, kac_pkg::MODE_ENTRY);
    add_row(kac_pkg::OP_TICK, 8'h5A, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    // five digits: the oldest one drops out
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd9, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd0, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd4, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd2, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd3, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_D, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd7, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_A, 1, "W0427", 1'b1, kac_pkg::MODE_ENTRY);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd0, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd4, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd2, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd3, 0, "", 1'b0, kac_pkg::MODE_IDLE);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_A, 1, "C0423", 1'b0, kac_pkg::MODE_DISARMED);
    add_row(kac_pkg::OP_KEY, kac_pkg::CH_0 + 8'd1, 1, "", 1'b0, kac_pkg::MODE_DISARMED);
    add_row(kac_pkg::OP_REARM, 8'h3C, 1, "R", 1'b0, kac_pkg::MODE_IDLE);

    foreach (script[n])
      send_event(script[n].op, script[n].key, script[n].typed, script[n].msg,
                 script[n].alarm, script[n].mode, hit);
    settle();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          code = 16'h0000;
          limit = 16'd0;
        end
        1: begin
          code = 16'h9999;
          limit = 16'hFFFF;
        end
        2: begin
          code = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                  4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
          limit = 16'd1;
        end
        3: begin
          // non-BCD nibbles never match
          code = 16'hFA5C;
          limit = 16'd3;
        end
        4: begin
          code = 16'($urandom_range(0, 65535));
          limit = 16'($urandom_range(1, 20));
        end
        default: begin
          code = kac_pkg::SECRET_RST;
          limit = kac_pkg::TIMEOUT_RST;
        end
      endcase
      program_reg(kac_pkg::REG_SECRET, code);
      program_reg(kac_pkg::REG_TIMEOUT, limit);
      calm = (phase == 2);
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        random_event(op, key);
        send_event(op, key, 0, "", 1'b0, kac_pkg::MODE_IDLE, hit);
        if (hit) done_items++;
      end
      settle();
    end

    if (errors == 0 && due_msg_bytes.size() == 0) begin
      $display("keypad_alarm_controller_top test passed");
    end else begin
      $display("keypad_alarm_controller_top test failed");
    end
    $finish;
  end

endmodule
